// File: rtl/scfr_pkg.sv
// Package for the sum-checked frame receiver.
// Holds the parser phase and status codes, the framing constants and the result record.
// No dependencies.
`timescale 1ns / 1ps

package scfr_pkg;

  localparam logic [7:0] SyncFirst    = 8'hAA;
  localparam logic [7:0] SyncSecond   = 8'h55;
  localparam logic [7:0] VersionReset = 8'h01;
  localparam int unsigned MinLength   = 5;
  localparam int unsigned HeaderBytes = 4;

  typedef enum logic [3:0] {
    PhHunt  = 4'd0,
    PhSync2 = 4'd1,
    PhLenLo = 4'd2,
    PhLenHi = 4'd3,
    PhVer   = 4'd4,
    PhSeq   = 4'd5,
    PhMod   = 4'd6,
    PhCmd   = 4'd7,
    PhData  = 4'd8,
    PhCsum  = 4'd9
  } phase_e;

  typedef enum logic [2:0] {
    StInFrame = 3'd0,
    StGood    = 3'd1,
    StCsumErr = 3'd2,
    StLenErr  = 3'd3,
    StAbort   = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [7:0] byte_index;
    logic       frame_last;
    status_e    status;
    logic [7:0] frame_module;
    logic [7:0] frame_command;
    logic [7:0] payload_length;
  } scfr_result_t;

endpackage

// File: rtl/scfr_if.sv
// Valid/ready stream interfaces for the received bytes and the frame results.
// No dependencies.
`timescale 1ns / 1ps

interface scfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface scfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [7:0] byte_index;
  logic       frame_last;
  logic [2:0] status;
  logic [7:0] frame_module;
  logic [7:0] frame_command;
  logic [7:0] payload_length;

  modport source (
    output valid, output frame_byte, output byte_index, output frame_last,
    output status, output frame_module, output frame_command,
    output payload_length, input ready
  );
  modport sink (
    input valid, input frame_byte, input byte_index, input frame_last,
    input status, input frame_module, input frame_command,
    input payload_length, output ready
  );
endinterface

// File: rtl/scfr_parser.sv
// Frame parser: phase register, frame bookkeeping and the version register.
// Decodes one accepted byte per cycle into at most one result. Uses scfr_pkg.
`timescale 1ns / 1ps

module scfr_parser #(
  parameter int unsigned MaxFrameBytes = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_fire_i,
  input  logic [7:0]           rx_byte_i,
  output logic                 res_valid_o,
  output scfr_pkg::scfr_result_t res_o
);
  import scfr_pkg::*;

  localparam int unsigned RemW = $clog2(MaxFrameBytes);

  phase_e          phase_q, phase_d;
  logic [RemW-1:0] remaining_q, remaining_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      position_q, position_d;
  logic [7:0]      len_lo_q, len_lo_d;
  logic [7:0]      module_q, module_d;
  logic [7:0]      command_q, command_d;
  logic [7:0]      payload_q, payload_d;
  logic [7:0]      version_q;

  logic [15:0]     len_w;
  logic            len_bad;
  logic [RemW-1:0] rem_dec;
  logic            to_csum;
  logic            last;
  status_e         status;
  logic [7:0]      base_idx;

  assign len_w   = {rx_byte_i, len_lo_q};
  assign len_bad = (len_w < 16'(MinLength))
                || (({1'b0, len_w} + 17'(HeaderBytes)) > 17'(MaxFrameBytes));
  assign rem_dec = remaining_q - RemW'(1);
  assign to_csum = rem_dec <= RemW'(1);

  always_comb begin
    last        = 1'b0;
    status      = StInFrame;
    res_valid_o = in_fire_i;
    base_idx    = position_q;
    case (phase_q)
      PhSync2: begin
        if (rx_byte_i != SyncSecond) begin
          last   = 1'b1;
          status = StAbort;
        end
      end
      PhLenHi: begin
        if (len_bad) begin
          last   = 1'b1;
          status = StLenErr;
        end
      end
      PhVer: begin
        if (rx_byte_i != version_q) begin
          last   = 1'b1;
          status = StAbort;
        end
      end
      PhCsum: begin
        last   = 1'b1;
        status = (rx_byte_i == sum_q) ? StGood : StCsumErr;
      end
      PhLenLo, PhSeq, PhMod, PhCmd, PhData: begin
        last = 1'b0;
      end
      default: begin
        base_idx = 8'd0;
        if (rx_byte_i != SyncFirst) begin
          res_valid_o = 1'b0;
        end
      end
    endcase
    res_o.frame_byte     = rx_byte_i;
    res_o.byte_index     = base_idx;
    res_o.frame_last     = last;
    res_o.status         = status;
    res_o.frame_module   = last ? module_q : 8'd0;
    res_o.frame_command  = last ? command_q : 8'd0;
    res_o.payload_length = last ? payload_q : 8'd0;
  end

  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    sum_d       = sum_q;
    position_d  = position_q;
    len_lo_d    = len_lo_q;
    module_d    = module_q;
    command_d   = command_q;
    payload_d   = payload_q;
    if (in_fire_i) begin
      case (phase_q)
        PhSync2: begin
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          len_lo_d = rx_byte_i;
          phase_d  = PhLenHi;
        end
        PhLenHi: begin
          if (!len_bad) begin
            remaining_d = len_w[RemW-1:0];
            sum_d       = 8'd0;
            phase_d     = PhVer;
          end
        end
        PhVer: begin
          if (rx_byte_i == version_q) begin
            sum_d       = sum_q + rx_byte_i;
            remaining_d = rem_dec;
            phase_d     = PhSeq;
          end
        end
        PhSeq: begin
          sum_d       = sum_q + rx_byte_i;
          remaining_d = rem_dec;
          phase_d     = PhMod;
        end
        PhMod: begin
          sum_d       = sum_q + rx_byte_i;
          remaining_d = rem_dec;
          module_d    = rx_byte_i;
          phase_d     = PhCmd;
        end
        PhCmd: begin
          sum_d       = sum_q + rx_byte_i;
          remaining_d = rem_dec;
          command_d   = rx_byte_i;
          phase_d     = to_csum ? PhCsum : PhData;
        end
        PhData: begin
          sum_d       = sum_q + rx_byte_i;
          remaining_d = rem_dec;
          payload_d   = payload_q + 8'd1;
          if (to_csum) begin
            phase_d = PhCsum;
          end
        end
        PhCsum: begin
          phase_d = PhHunt;
        end
        default: begin
          phase_d = PhHunt;
          if (rx_byte_i == SyncFirst) begin
            sum_d       = 8'd0;
            remaining_d = '0;
            len_lo_d    = 8'd0;
            module_d    = 8'd0;
            command_d   = 8'd0;
            payload_d   = 8'd0;
            phase_d     = PhSync2;
          end
        end
      endcase
      if (res_valid_o) begin
        position_d = base_idx + 8'd1;
        if (last) begin
          phase_d = PhHunt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      remaining_q <= '0;
      sum_q       <= 8'd0;
      position_q  <= 8'd0;
      len_lo_q    <= 8'd0;
      module_q    <= 8'd0;
      command_q   <= 8'd0;
      payload_q   <= 8'd0;
      version_q   <= VersionReset;
    end else begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      sum_q       <= sum_d;
      position_q  <= position_d;
      len_lo_q    <= len_lo_d;
      module_q    <= module_d;
      command_q   <= command_d;
      payload_q   <= payload_d;
      if (cfg_we_i) begin
        version_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// File: rtl/scfr_out_stage.sv
// Result register between the parser and the output channel.
// Holds one result and frees itself in the cycle it is taken. Uses scfr_pkg.
`timescale 1ns / 1ps

module scfr_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  scfr_pkg::scfr_result_t in_data_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  output scfr_pkg::scfr_result_t out_data_o,
  input  logic                   out_ready_i
);
  import scfr_pkg::*;

  logic         valid_q, valid_d;
  scfr_result_t data_q;

  assign ready_o     = !valid_q || out_ready_i;
  assign valid_d     = ready_o ? in_valid_i : valid_q;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

// File: rtl/sum_checked_frame_receiver_unit.sv
// Top level of the sum-checked frame receiver.
// Instantiates scfr_parser and scfr_out_stage; uses scfr_pkg and scfr_if.
//
//   Channel   Direction  Handshake          Contents
//   rx_if     in         valid/ready        rx_byte
//   tx_if     out        valid/ready        byte, index, last, status, module, command, length
//   cfg       in         cfg_we_i           expected version byte
//
// One byte per cycle is accepted while ready; any result is registered in the next cycle.
// The input is ready whenever the result register is empty or is being emptied.
// A stalled output holds its result and stops input only while the register stays full.
// Reset returns the parser to hunting and the version register to one; no clearing pass.
`timescale 1ns / 1ps

module sum_checked_frame_receiver_unit #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  scfr_in_if.sink    rx_if,
  scfr_out_if.source tx_if
);
  import scfr_pkg::*;

  logic         in_fire;
  logic         stage_ready;
  logic         res_valid;
  scfr_result_t res;
  scfr_result_t out_data;

  assign rx_if.ready = stage_ready;
  assign in_fire     = rx_if.valid && stage_ready;

  scfr_parser #(
    .MaxFrameBytes(MAX_FRAME_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_fire_i  (in_fire),
    .rx_byte_i  (rx_if.rx_byte),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  scfr_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (res_valid),
    .in_data_i  (res),
    .ready_o    (stage_ready),
    .out_valid_o(tx_if.valid),
    .out_data_o (out_data),
    .out_ready_i(tx_if.ready)
  );

  assign tx_if.frame_byte     = out_data.frame_byte;
  assign tx_if.byte_index     = out_data.byte_index;
  assign tx_if.frame_last     = out_data.frame_last;
  assign tx_if.status         = out_data.status;
  assign tx_if.frame_module   = out_data.frame_module;
  assign tx_if.frame_command  = out_data.frame_command;
  assign tx_if.payload_length = out_data.payload_length;

endmodule

// File: rtl/scfr_checker.sv
// Port-level checker for the sum-checked frame receiver, bound to the top level.
// Uses scfr_pkg for the framing constants and status codes.
`timescale 1ns / 1ps

module scfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] frame_byte_i,
  input logic [7:0] byte_index_i,
  input logic       frame_last_i,
  input logic [2:0] status_i
);
  import scfr_pkg::*;

  logic out_fire;

  assign out_fire = out_valid_i && out_ready_i;

  // The parser is never stalled while the result register is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
  else $error("input stalled with an empty result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(frame_byte_i)
      && $stable(byte_index_i) && $stable(status_i))
  else $error("stalled result changed");

  // Back-to-back results inside one frame carry consecutive indexes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !frame_last_i) ##1 out_fire
      |-> byte_index_i == $past(byte_index_i) + 8'd1)
  else $error("byte index did not advance within a frame");

  // A result right after a frame end must open a new frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && frame_last_i) ##1 out_fire
      |-> byte_index_i == 8'd0 && frame_byte_i == SyncFirst
        && status_i == StInFrame)
  else $error("new frame did not start at the first sync byte");

  // An interior byte on the output reports the in-frame status, checked while input is valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && in_valid_i && !frame_last_i |-> status_i == StInFrame)
  else $error("end status without frame end");

endmodule

bind sum_checked_frame_receiver_unit scfr_checker u_scfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (rx_if.valid),
  .in_ready_i  (rx_if.ready),
  .out_valid_i (tx_if.valid),
  .out_ready_i (tx_if.ready),
  .frame_byte_i(tx_if.frame_byte),
  .byte_index_i(tx_if.byte_index),
  .frame_last_i(tx_if.frame_last),
  .status_i    (tx_if.status)
);
